[rtl/srom_pkg.sv]
// shared constants, codes and types of the segmented range ordinal mapper
// no dependencies; imported by every module of the block
`default_nettype none

package srom_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // datapath widths
    localparam int VAL_W = 32;
    localparam int KEY_W = 64;
    localparam int INC_W = 31;
    localparam int QUO_W = 32;

    // stream widths
    localparam int S_DATA_W = 136;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 1;

    // item modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // entry kinds
    localparam logic [1:0] KIND_RANGE  = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_SETKEY = 2'd2;
    localparam logic [1:0] KIND_SETINC = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] first;
        logic [VAL_W-1:0] last;
    } srom_entry_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] index;
        srom_entry_t      entry;
        logic [VAL_W-1:0] query;
        logic [VAL_W-1:0] start_key;
    } srom_item_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        srom_entry_t      wr_entry;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } srom_mem_req_t;

    // sign extension of a 32-bit value to key width
    function automatic logic [KEY_W-1:0] sx64(input logic [VAL_W-1:0] v);
        sx64 = {{(KEY_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

[rtl/srom_table.sv]
// segment table: one synchronous memory, one write and one registered read port
// depends on srom_pkg for the entry type and the memory request struct
`default_nettype none

module srom_table (
    input  wire                      clk,
    input  srom_pkg::srom_mem_req_t  req,
    output srom_pkg::srom_entry_t    rd_entry
);
    import srom_pkg::*;

    srom_entry_t mem [TABLE_DEPTH];
    srom_entry_t rd_entry_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_entry_reg <= mem[req.rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

[rtl/srom_div.sv]
// restoring divider, one quotient bit per cycle, 32 steps
// depends on srom_pkg for widths; the quotient must fit in QUO_W bits
`default_nettype none

module srom_div (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [srom_pkg::KEY_W-1:0]      dividend,
    input  wire [srom_pkg::INC_W-1:0]      divisor,
    output logic                           done,
    output logic [srom_pkg::QUO_W-1:0]     quotient
);
    import srom_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [INC_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  sh_reg, sh_next;
    logic [INC_W-1:0]  dvsr_reg, dvsr_next;

    logic [INC_W:0]    trial;
    logic [INC_W:0]    diff;
    logic              ge;

    // one trial subtraction
    assign trial = {rem_reg, sh_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign ge    = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            // upper half is below the divisor since the quotient fits
            busy_next = 1'b1;
            cnt_next  = STEP_W'(QUO_W - 1);
            rem_next  = dividend[QUO_W +: INC_W];
            sh_next   = dividend[QUO_W-1:0];
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[INC_W-1:0] : trial[INC_W-1:0];
            sh_next  = {sh_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

[rtl/srom_walker.sv]
// sequencer that walks the segment table for one item at a time
// depends on srom_pkg; drives srom_table and srom_div, holds key, increment and result
`default_nettype none

module srom_walker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  srom_pkg::srom_item_t           req,
    input  wire [srom_pkg::CNT_W-1:0]      n_ent,
    output logic                           idle,
    output logic                           res_valid,
    input  wire                            res_ready,
    output logic                           res_found,
    output logic [srom_pkg::KEY_W-1:0]     res_answer,
    output srom_pkg::srom_mem_req_t        mem_req,
    input  srom_pkg::srom_entry_t          rd_entry,
    output logic                           div_start,
    output logic [srom_pkg::KEY_W-1:0]     div_dividend,
    output logic [srom_pkg::INC_W-1:0]     div_divisor,
    input  wire                            div_done,
    input  wire [srom_pkg::QUO_W-1:0]      div_quot
);
    import srom_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             decode_reg, decode_next;
    logic [VAL_W-1:0] q_reg, q_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [INC_W-1:0] inc_reg, inc_next;
    logic [KEY_W-1:0] prod_reg, prod_next;
    logic             hit_reg, hit_next;
    logic             found_reg, found_next;
    logic [KEY_W-1:0] ans_reg, ans_next;

    logic [VAL_W-1:0] lo, hi;
    logic [KEY_W-1:0] lo_x, q_x;
    logic             ordered, enc_in, dec_cand;
    logic [VAL_W:0]   op_a;
    logic [KEY_W:0]   prod_full;
    logic [KEY_W-1:0] off;
    logic [KEY_W-1:0] key_adv;
    logic             last_ent;
    logic [IDX_W-1:0] idx_inc;
    logic             step;

    // entry compares, all signed
    assign lo       = rd_entry.first;
    assign hi       = rd_entry.last;
    assign lo_x     = sx64(lo);
    assign q_x      = sx64(q_reg);
    assign ordered  = $signed(hi) >= $signed(lo);
    assign enc_in   = ordered && ($signed(q_reg) >= $signed(lo))
                      && ($signed(q_reg) <= $signed(hi));
    assign dec_cand = ordered && ($signed(key_reg) <= $signed(q_x));

    // one multiply per range entry: offset on an encode hit, else the span
    assign op_a      = (!decode_reg && enc_in) ? ({q_reg[VAL_W-1], q_reg} - {lo[VAL_W-1], lo})
                                               : ({hi[VAL_W-1], hi} - {lo[VAL_W-1], lo});
    assign prod_full = $signed(op_a) * $signed({1'b0, inc_reg});

    // key offset for decode and key after a missed range
    assign off     = q_x - key_reg;
    assign key_adv = key_reg + prod_reg + {{(KEY_W-INC_W){1'b0}}, inc_reg};

    assign idx_inc  = idx_reg + IDX_W'(1);
    assign last_ent = ({1'b0, idx_reg} + CNT_W'(1)) == n_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        decode_next = decode_reg;
        q_next      = q_reg;
        key_next    = key_reg;
        inc_next    = inc_reg;
        prod_next   = prod_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        ans_next    = ans_reg;
        mem_req     = '0;
        div_start   = 1'b0;
        step        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    q_next      = req.query;
                    key_next    = sx64(req.start_key);
                    inc_next    = INC_W'(1);
                    decode_next = (req.mode == MODE_DECODE);
                    idx_next    = '0;
                    n_next      = n_ent;
                    found_next  = 1'b0;
                    ans_next    = '1;
                    state_next  = ST_DONE;
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            mem_req.wr_en    = 1'b1;
                            mem_req.wr_addr  = req.index;
                            mem_req.wr_entry = req.entry;
                        end
                        MODE_ENCODE, MODE_DECODE:
                        begin
                            if (n_ent != '0)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                state_next      = ST_EVAL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_EVAL:
            begin
                case (rd_entry.kind)
                    KIND_RANGE:
                    begin
                        prod_next  = prod_full[KEY_W-1:0];
                        hit_next   = decode_reg ? dec_cand : enc_in;
                        state_next = ST_ACC;
                    end
                    KIND_SINGLE:
                    begin
                        if (decode_reg ? (key_reg == q_x) : (lo == q_reg))
                        begin
                            found_next = 1'b1;
                            ans_next   = decode_reg ? lo_x : key_reg;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            key_next = key_reg + {{(KEY_W-INC_W){1'b0}}, inc_reg};
                            step     = 1'b1;
                        end
                    end
                    KIND_SETKEY:
                    begin
                        key_next = lo_x;
                        step     = 1'b1;
                    end
                    default:
                    begin
                        // increment stays positive
                        inc_next = ($signed(lo) <= 0) ? INC_W'(1) : lo[INC_W-1:0];
                        step     = 1'b1;
                    end
                endcase
            end

            ST_ACC:
            begin
                if (!decode_reg && hit_reg)
                begin
                    found_next = 1'b1;
                    ans_next   = key_reg + prod_reg;
                    state_next = ST_DONE;
                end
                else if (decode_reg && hit_reg && (off <= prod_reg))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    key_next = key_adv;
                    step     = 1'b1;
                end
            end

            ST_DIV:
            begin
                // entry read data is still held from the range entry
                if (div_done)
                begin
                    found_next = 1'b1;
                    ans_next   = lo_x + {{(KEY_W-QUO_W){1'b0}}, div_quot};
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move on to the next entry, prefetching it
        if (step)
        begin
            if (last_ent)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                idx_next        = idx_inc;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_inc;
                state_next      = ST_EVAL;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        decode_reg <= decode_next;
        q_reg      <= q_next;
        key_reg    <= key_next;
        inc_reg    <= inc_next;
        prod_reg   <= prod_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        ans_reg    <= ans_next;
    end

    assign idle         = (state_reg == ST_IDLE);
    assign res_valid    = (state_reg == ST_DONE);
    assign res_found    = found_reg;
    assign res_answer   = ans_reg;
    assign div_dividend = off;
    assign div_divisor  = inc_reg;

endmodule

`default_nettype wire

[rtl/segmented_range_ordinal_mapper.sv]
// top level of the segmented range ordinal mapper: stream ports, config register, output register
// depends on srom_pkg, srom_table, srom_div and srom_walker
//
//   channel  handshake               payload
//   s_       s_tvalid / s_tready     s_tdata (136b), s_tuser (4b)  item in
//   m_       m_tvalid / m_tready     m_tdata (64b), m_tuser (1b)   result out
//   cfg_     cfg_valid / cfg_ready   cfg_data (5b)                 active entry count
//
// a load or an idle-mode item goes straight to the done state; s_tready is high again once its result is handed off
// a query first reads the table, then takes the evaluate state for each key, increment or
// single entry and the evaluate and accumulate states for each range entry (read, multiply, add),
// then hands off the result; a decode hit inside a range also runs the one-bit-per-cycle divider
// the finished result waits in the output register while the next item is accepted
// the table needs no clearing after reset; cfg_ready is always high
`default_nettype none

module segmented_range_ordinal_mapper (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // entry_index, first_value, last_value, query, start_key, zero pad
    input  wire [srom_pkg::S_DATA_W-1:0]    s_tdata,
    // mode, entry_kind
    input  wire [srom_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // answer
    output logic [srom_pkg::M_DATA_W-1:0]   m_tdata,
    // found
    output logic [srom_pkg::M_USER_W-1:0]   m_tuser,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [srom_pkg::CNT_W-1:0]       cfg_data
);
    import srom_pkg::*;

    logic [CNT_W-1:0]    active_reg;
    logic [CNT_W-1:0]    n_ent;
    srom_item_t          req;
    logic                start;
    logic                idle;
    logic                res_valid;
    logic                res_ready;
    logic                res_found;
    logic [KEY_W-1:0]    res_answer;
    srom_mem_req_t       mem_req;
    srom_entry_t         rd_entry;
    logic                div_start;
    logic [KEY_W-1:0]    div_dividend;
    logic [INC_W-1:0]    div_divisor;
    logic                div_done;
    logic [QUO_W-1:0]    div_quot;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_USER_W-1:0] out_user_reg;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    // clamp the walk to the table depth
    assign n_ent = (active_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : active_reg;

    // unpack the input item
    assign req.mode        = s_tuser[1:0];
    assign req.entry.kind  = s_tuser[3:2];
    assign req.index       = s_tdata[IDX_W-1:0];
    assign req.entry.first = s_tdata[IDX_W +: VAL_W];
    assign req.entry.last  = s_tdata[IDX_W + VAL_W +: VAL_W];
    assign req.query       = s_tdata[IDX_W + 2*VAL_W +: VAL_W];
    assign req.start_key   = s_tdata[IDX_W + 3*VAL_W +: VAL_W];

    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;

    srom_table u_table (
        .clk      (clk),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    srom_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    srom_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .n_ent        (n_ent),
        .idle         (idle),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_found    (res_found),
        .res_answer   (res_answer),
        .mem_req      (mem_req),
        .rd_entry     (rd_entry),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_answer;
            out_user_reg <= M_USER_W'(res_found);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

[rtl/srom_checker.sv]
// port-level checks of the segmented range ordinal mapper, bound to the top level
// depends on srom_pkg for widths and on the top level's port names
`default_nettype none

module srom_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [srom_pkg::M_DATA_W-1:0]    m_tdata,
    input wire [srom_pkg::M_USER_W-1:0]    m_tuser
);
    import srom_pkg::*;

    // one item at a time: an accepted item closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready right after an item was accepted");

    // a miss always answers minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == {M_DATA_W{1'b1}})
        else $error("not-found result with an answer other than minus one");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind segmented_range_ordinal_mapper srom_checker u_srom_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
